// ----- rtl/gnf_pkg.sv -----
`default_nettype none

package gnf_pkg;

  // Field widths of the request and result words.
  localparam int unsigned ReqTypeW = 1;
  localparam int unsigned PermW    = 8;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned NoiseW   = 16;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COORD_SCALE  = 3'd0,
    CFG_LACUNARITY   = 3'd1,
    CFG_OCTAVE_GAIN  = 3'd2,
    CFG_OCTAVE_COUNT = 3'd3,
    CFG_NORM_SCALE   = 3'd4
  } cfg_reg_e;

  // Request type codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // Constants for the gradient table, Q2.30.
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_PC, ST_PR, ST_PRC, ST_X, ST_Y, ST_RD0, ST_RD1,
    ST_H0, ST_H1, ST_H2, ST_H3, ST_G3, ST_DOT, ST_SX0, ST_SX1, ST_SX2,
    ST_SY0, ST_SY1, ST_SY2, ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_NZ,
    ST_ACC, ST_FREQ, ST_AMP, ST_UPD, ST_NORM, ST_FIN
  } gnf_state_e;

  // Round a Q2.30 magnitude to Q1.15, saturate and apply the sign.
  function automatic logic [15:0] to_q15(input logic [63:0] m30, input logic neg);
    logic [63:0] m;
    logic [15:0] r;
    m = (m30 + 64'd16384) >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    r = m[15:0];
    return neg ? 16'(-r) : r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gnf_ifs.sv -----
`default_nettype none

// Request channel: permutation loads and pixel evaluations.
interface gnf_req_if;
  import gnf_pkg::*;
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [PermW-1:0]    perm_index;
  logic [PermW-1:0]    perm_value;
  logic [CoordW-1:0]   col;
  logic [CoordW-1:0]   row;

  modport source (output valid, req_type, perm_index, perm_value, col, row, input ready);
  modport sink   (input valid, req_type, perm_index, perm_value, col, row, output ready);
endinterface

// Result channel: one noise value per evaluation.
interface gnf_res_if;
  import gnf_pkg::*;
  logic              valid;
  logic              ready;
  logic [NoiseW-1:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/gradient_noise_fbm.sv -----
// Channel   Dir  Handshake     Word
// req_i     in   valid/ready   req_type, perm_index, perm_value, col, row
// res_o     out  valid/ready   noise_value
// cfg       in   cfg_we_i      cfg_index_i, cfg_wdata_i (no handshake)
//
// An evaluation runs the sequencer once per octave, then normalises into the result register;
// every product goes through the one shared multiplier, one per cycle.
// A load word is taken in the idle state and gives no result.
// After reset a clearing pass fills the permutation memory with the identity permutation.
// The result register holds its word until taken; a new request may enter meanwhile.
// TABLE_DEPTH must be a power of two.

`default_nettype none

module gradient_noise_fbm import gnf_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned MAX_OCTAVES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  gnf_req_if.sink                  req_i,
  gnf_res_if.source                res_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned OctW = $clog2(MAX_OCTAVES + 1);
  localparam int unsigned SumW = 34 + $clog2(MAX_OCTAVES);
  localparam logic [IdxW-1:0] ClrLast = IdxW'(TABLE_DEPTH - 1);
  localparam logic [5:0]      MaxOct6 = 6'(MAX_OCTAVES);

  // Fixed gradient table: cos in the upper half, sin in the lower half.
  logic [31:0] grad_rom [TABLE_DEPTH];

  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] QQ = (64'(8 * gi) + 64'(TABLE_DEPTH)) / 64'(2 * TABLE_DEPTH);
    localparam longint RR = longint'(4 * gi) - longint'(QQ) * longint'(TABLE_DEPTH);
    localparam logic [63:0] AR = (RR < 0) ? 64'(-RR) : 64'(RR);
    localparam logic [63:0] AA = PI_Q30 * AR / 64'(2 * TABLE_DEPTH);
    localparam logic [63:0] TT = (AA * AA) >> 30;
    localparam logic [63:0] SP1 = Q30_ONE - TT / 72;
    localparam logic [63:0] SP2 = Q30_ONE - ((TT * SP1) >> 30) / 42;
    localparam logic [63:0] SP3 = Q30_ONE - ((TT * SP2) >> 30) / 20;
    localparam logic [63:0] SP4 = Q30_ONE - ((TT * SP3) >> 30) / 6;
    localparam logic [63:0] SN  = (AA * SP4) >> 30;
    localparam logic [63:0] CP1 = Q30_ONE - TT / 90;
    localparam logic [63:0] CP2 = Q30_ONE - ((TT * CP1) >> 30) / 56;
    localparam logic [63:0] CP3 = Q30_ONE - ((TT * CP2) >> 30) / 30;
    localparam logic [63:0] CP4 = Q30_ONE - ((TT * CP3) >> 30) / 12;
    localparam logic [63:0] CP5 = Q30_ONE - ((TT * CP4) >> 30) / 2;
    localparam logic [15:0] C0 = to_q15(CP5, 1'b0);
    localparam logic [15:0] S0 = to_q15(SN, RR < 0);
    localparam logic [15:0] CV = (QQ[1:0] == 2'd0) ? C0 :
                                 (QQ[1:0] == 2'd1) ? 16'(-S0) :
                                 (QQ[1:0] == 2'd2) ? 16'(-C0) : S0;
    localparam logic [15:0] SV = (QQ[1:0] == 2'd0) ? S0 :
                                 (QQ[1:0] == 2'd1) ? C0 :
                                 (QQ[1:0] == 2'd2) ? 16'(-S0) : 16'(-C0);
    assign grad_rom[gi] = {CV, SV};
  end

  // Round half away from zero on the magnitude, by 16 bits.
  function automatic logic signed [65:0] rnd16(input logic signed [65:0] v);
    logic [65:0] m;
    logic [65:0] r;
    m = v[65] ? 66'(-v) : 66'(v);
    r = (m + 66'd32768) >> 16;
    return v[65] ? $signed(66'(-r)) : $signed(r);
  endfunction

  // Cubic s-curve from t^2 and t^3, Q0.16.
  function automatic logic [16:0] scurve(input logic [31:0] t2, input logic [47:0] t3);
    logic [51:0] v;
    v = {4'b0, t2, 16'b0} + {3'b0, t2, 17'b0} - {3'b0, t3, 1'b0} + 52'h0_0000_8000_0000;
    return v[48:32];
  endfunction

  // Configuration registers.
  logic [23:0] cs_q, lac_q;
  logic [16:0] gain_q, norm_q;
  logic [4:0]  ocnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q   <= 24'd4096;
      lac_q  <= 24'd131072;
      gain_q <= 17'd32768;
      ocnt_q <= 5'd1;
      norm_q <= 17'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COORD_SCALE:  cs_q   <= cfg_wdata_i;
        CFG_LACUNARITY:   lac_q  <= cfg_wdata_i;
        CFG_OCTAVE_GAIN:  gain_q <= cfg_wdata_i[16:0];
        CFG_OCTAVE_COUNT: ocnt_q <= cfg_wdata_i[4:0];
        CFG_NORM_SCALE:   norm_q <= cfg_wdata_i[16:0];
        default: ;
      endcase
    end
  end

  gnf_state_e state_q, state_d;
  logic [IdxW-1:0] clr_q;
  logic [3:0]      cnt_q;
  logic            out_valid_q;
  logic [15:0]     out_q;
  logic [OctW-1:0] oct_left_q;

  logic [15:0] col_q, row_q, fx_q, fy_q;
  logic [39:0] pc_q, pr_q;
  logic [23:0] f_q;
  logic [16:0] amp_q, sx_q, sy_q, n_q;
  logic [SumW-1:0] sum_q;
  logic [IdxW-1:0] ix_q, iy_q;
  logic [7:0]  piy_q, piy1_q, rdata_q;
  logic [31:0] grad_q [4];
  logic signed [35:0] dot_q [4];
  logic signed [35:0] e0_q, e1_q;
  logic [31:0] t2_q;

  // Shared multiplier with a registered product.
  logic signed [40:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [65:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Permutation memory, one write and one registered read port.
  logic [7:0]      perm_mem [TABLE_DEPTH];
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      perm_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= perm_mem[mem_raddr];
  end

  logic req_acc, load_ok;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign load_ok     = (11'(req_i.perm_index) < 11'(TABLE_DEPTH));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 8'(clr_q);
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (req_acc && req_i.req_type == REQ_LOAD && load_ok) begin
      mem_we    = 1'b1;
      mem_waddr = IdxW'(req_i.perm_index);
      mem_wdata = req_i.perm_value;
    end
  end

  // Operands for the dot products, blend differences, rounding terms and the octave start.
  logic [1:0]         dot_k;
  logic [2:0]         dot_j;
  logic signed [16:0] dot_off;
  logic signed [15:0] dot_grad;
  logic signed [35:0] diff0, diff1, diff2;
  logic signed [65:0] nz_full;
  logic [48:0]        f_rnd;
  logic [34:0]        a_rnd;
  logic [57:0]        o_rnd;
  logic [5:0]         oc6;
  logic [OctW-1:0]    oct_start;

  assign dot_k    = cnt_q[2:1];
  assign dot_j    = 3'(cnt_q - 4'd1);
  assign dot_off  = cnt_q[0] ? $signed({dot_k[1], fy_q}) : $signed({dot_k[0], fx_q});
  assign dot_grad = cnt_q[0] ? $signed(grad_q[dot_k][15:0]) : $signed(grad_q[dot_k][31:16]);
  assign diff0    = dot_q[1] - dot_q[0];
  assign diff1    = dot_q[3] - dot_q[2];
  assign diff2    = e1_q - e0_q;
  assign nz_full  = 66'sd32768 + rnd16(66'(e0_q));
  assign f_rnd    = prod_q[48:0] + 49'd32768;
  assign a_rnd    = prod_q[34:0] + 35'd32768;
  assign o_rnd    = prod_q[57:0] + 58'h0_8000_0000;
  assign oc6      = {1'b0, ocnt_q};
  assign oct_start = (oc6 == 6'd0) ? OctW'(1) :
                     (oc6 > MaxOct6) ? OctW'(MAX_OCTAVES) : OctW'(oc6);

  // Next state, multiplier operands and read address.
  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    mem_raddr = iy_q;
    case (state_q)
      ST_CLEAR: if (clr_q == ClrLast) state_d = ST_IDLE;
      ST_IDLE: begin
        if (req_acc && req_i.req_type == REQ_EVAL) state_d = ST_PC;
      end
      ST_PC: begin
        mul_a = 41'(cs_q);  mul_b = 25'(col_q); state_d = ST_PR;
      end
      ST_PR: begin
        mul_a = 41'(cs_q);  mul_b = 25'(row_q); state_d = ST_PRC;
      end
      ST_PRC: state_d = ST_X;
      ST_X: begin
        mul_a = 41'(pc_q);  mul_b = 25'(f_q);   state_d = ST_Y;
      end
      ST_Y: begin
        mul_a = 41'(pr_q);  mul_b = 25'(f_q);   state_d = ST_RD0;
      end
      ST_RD0: begin
        mem_raddr = prod_q[32 +: IdxW]; state_d = ST_RD1;
      end
      ST_RD1: begin
        mem_raddr = iy_q + IdxW'(1); state_d = ST_H0;
      end
      ST_H0: begin
        mem_raddr = ix_q + IdxW'(piy_q); state_d = ST_H1;
      end
      ST_H1: begin
        mem_raddr = ix_q + IdxW'(1) + IdxW'(piy_q); state_d = ST_H2;
      end
      ST_H2: begin
        mem_raddr = ix_q + IdxW'(piy1_q); state_d = ST_H3;
      end
      ST_H3: begin
        mem_raddr = ix_q + IdxW'(1) + IdxW'(piy1_q); state_d = ST_G3;
      end
      ST_G3: state_d = ST_DOT;
      ST_DOT: begin
        if (cnt_q < 4'd8) begin
          mul_a = 41'(dot_off);
          mul_b = 25'(dot_grad);
        end else begin
          state_d = ST_SX0;
        end
      end
      ST_SX0: begin
        mul_a = 41'(fx_q); mul_b = 25'(fx_q); state_d = ST_SX1;
      end
      ST_SX1: begin
        mul_a = 41'(prod_q[31:0]); mul_b = 25'(fx_q); state_d = ST_SX2;
      end
      ST_SX2: state_d = ST_SY0;
      ST_SY0: begin
        mul_a = 41'(fy_q); mul_b = 25'(fy_q); state_d = ST_SY1;
      end
      ST_SY1: begin
        mul_a = 41'(prod_q[31:0]); mul_b = 25'(fy_q); state_d = ST_SY2;
      end
      ST_SY2: state_d = ST_B0;
      ST_B0: begin
        mul_a = 41'(diff0); mul_b = 25'(sx_q); state_d = ST_B1;
      end
      ST_B1: begin
        mul_a = 41'(diff1); mul_b = 25'(sx_q); state_d = ST_B2;
      end
      ST_B2: state_d = ST_B3;
      ST_B3: begin
        mul_a = 41'(diff2); mul_b = 25'(sy_q); state_d = ST_B4;
      end
      ST_B4: state_d = ST_NZ;
      ST_NZ: state_d = ST_ACC;
      ST_ACC: begin
        mul_a = 41'(amp_q); mul_b = 25'(n_q); state_d = ST_FREQ;
      end
      ST_FREQ: begin
        mul_a = 41'(f_q); mul_b = 25'(lac_q); state_d = ST_AMP;
      end
      ST_AMP: begin
        mul_a = 41'(amp_q); mul_b = 25'(gain_q); state_d = ST_UPD;
      end
      ST_UPD: state_d = (oct_left_q == OctW'(1)) ? ST_NORM : ST_X;
      ST_NORM: begin
        mul_a = 41'(sum_q); mul_b = 25'(norm_q); state_d = ST_FIN;
      end
      ST_FIN: begin
        mul_a = 41'(sum_q); mul_b = 25'(norm_q);
        if (!out_valid_q || res_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      oct_left_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + IdxW'(1);
      if (state_q == ST_G3) begin
        cnt_q <= '0;
      end else if (state_q == ST_DOT) begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (req_acc && req_i.req_type == REQ_EVAL) begin
        oct_left_q <= oct_start;
      end else if (state_q == ST_UPD) begin
        oct_left_q <= oct_left_q - OctW'(1);
      end
      if (state_q == ST_FIN && state_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_acc && req_i.req_type == REQ_EVAL) begin
          col_q <= req_i.col;
          row_q <= req_i.row;
          f_q   <= 24'd65536;
          amp_q <= 17'd65536;
          sum_q <= '0;
        end
      end
      ST_PR:  pc_q <= prod_q[39:0];
      ST_PRC: pr_q <= prod_q[39:0];
      ST_Y: begin
        ix_q <= prod_q[32 +: IdxW];
        fx_q <= prod_q[31:16];
      end
      ST_RD0: begin
        iy_q <= prod_q[32 +: IdxW];
        fy_q <= prod_q[31:16];
      end
      ST_RD1: piy_q  <= rdata_q;
      ST_H0:  piy1_q <= rdata_q;
      ST_H1:  grad_q[0] <= grad_rom[IdxW'(rdata_q)];
      ST_H2:  grad_q[1] <= grad_rom[IdxW'(rdata_q)];
      ST_H3:  grad_q[2] <= grad_rom[IdxW'(rdata_q)];
      ST_G3:  grad_q[3] <= grad_rom[IdxW'(rdata_q)];
      ST_DOT: begin
        // Even terms start a corner's dot product, odd terms complete it.
        if (cnt_q != 4'd0) begin
          if (!dot_j[0]) begin
            dot_q[dot_j[2:1]] <= 36'(prod_q);
          end else begin
            dot_q[dot_j[2:1]] <= dot_q[dot_j[2:1]] + 36'(prod_q);
          end
        end
      end
      ST_SX1: t2_q <= prod_q[31:0];
      ST_SX2: sx_q <= scurve(t2_q, prod_q[47:0]);
      ST_SY1: t2_q <= prod_q[31:0];
      ST_SY2: sy_q <= scurve(t2_q, prod_q[47:0]);
      ST_B1:  e0_q <= dot_q[0] + 36'(rnd16(prod_q));
      ST_B2:  e1_q <= dot_q[2] + 36'(rnd16(prod_q));
      ST_B4:  e0_q <= e0_q + 36'(rnd16(prod_q));
      ST_NZ: begin
        // Map the blended value to [0,1] and clamp.
        if (nz_full < 66'sd0) begin
          n_q <= '0;
        end else if (nz_full > 66'sd65536) begin
          n_q <= 17'd65536;
        end else begin
          n_q <= nz_full[16:0];
        end
      end
      ST_FREQ: sum_q <= sum_q + SumW'(prod_q[33:0]);
      ST_AMP: f_q <= (|f_rnd[48:40]) ? 24'hFF_FFFF : f_rnd[39:16];
      ST_UPD: amp_q <= (|a_rnd[34:33]) ? 17'h1_FFFF : a_rnd[32:16];
      ST_FIN: begin
        if (state_d == ST_IDLE) begin
          out_q <= (|o_rnd[57:48]) ? 16'hFFFF : o_rnd[47:32];
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.noise_value = out_q;

`ifndef SYNTH
  // Octave count stays within range at the start of each octave.
  a_oct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_X) |-> (oct_left_q != '0 && oct_left_q <= OctW'(MAX_OCTAVES)))
    else $error("octave counter out of range");

  // The clamped noise value never exceeds one.
  a_noise_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> (n_q <= 17'd65536))
    else $error("octave noise above one");

  // A load word leaves the block idle.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.req_type == REQ_LOAD) |=> (state_q == ST_IDLE))
    else $error("load left the idle state");

  // A result appears only from the final step.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result raised outside the final step");
`endif

endmodule

`default_nettype wire
